FILE: rtl/sha256_pkg.sv
// Package for the SHA-256 stream hasher: constants, round table, a rotate helper
// and the command struct shared by controller and datapath.
// No dependencies.
package sha256_pkg;

	localparam int unsigned WordW = 32;

	typedef logic [WordW-1:0] word_t;

	typedef enum logic [2:0] {
		LOAD_NONE,
		LOAD_BYTE,
		LOAD_PAD80,
		LOAD_ZERO,
		LOAD_LEN
	} load_op_t;

	// Commands from controller to datapath.
	typedef struct packed {
		load_op_t   load_op;    // what to write into the block buffer
		logic [5:0] load_addr;  // byte position for the write
		logic       count_byte; // add eight bits to the message length
		logic       comp_start; // copy chain value into round variables
		logic       comp_round; // run one round
		logic [5:0] round_idx;  // round number
		logic       comp_done;  // add round variables into chain value
		logic       finish;     // restore initial chain value and clear length
		logic [2:0] out_idx;    // digest word to present
	} sha_cmd_t;

	function automatic word_t init_hash(input logic [2:0] i);
		word_t r;
		case (i)
			3'd0: r = 32'h6a09e667;
			3'd1: r = 32'hbb67ae85;
			3'd2: r = 32'h3c6ef372;
			3'd3: r = 32'ha54ff53a;
			3'd4: r = 32'h510e527f;
			3'd5: r = 32'h9b05688c;
			3'd6: r = 32'h1f83d9ab;
			default: r = 32'h5be0cd19;
		endcase
		return r;
	endfunction

	localparam word_t RoundK [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	function automatic word_t rotr(input word_t x, input int unsigned n);
		return (x >> n) | (x << (WordW - n));
	endfunction

endpackage

FILE: rtl/sha256_datapath.sv
// Datapath of the SHA-256 hasher: block buffer, length counter, message schedule,
// one-round compression unit and chaining state. Depends on sha256_pkg.
module sha256_datapath
	import sha256_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  sha_cmd_t   cmd,
	input  logic [7:0] message_byte,
	output word_t      digest_word
);

	word_t       block_q [16];
	logic [63:0] bit_count_q;
	word_t       chain_q [8];
	word_t       sched_q [16];
	word_t       var_q [8];
	logic [7:0]  wr_byte;
	word_t       w_in, w_new, s0, s1, t1, t2;
	logic [5:0]  ridx;

	// Byte selected for the block buffer write.
	always_comb begin
		case (cmd.load_op)
			LOAD_BYTE:  wr_byte = message_byte;
			LOAD_PAD80: wr_byte = 8'h80;
			LOAD_LEN:   wr_byte = bit_count_q[8*(7-cmd.load_addr[2:0]) +: 8];
			default:    wr_byte = 8'h00;
		endcase
	end

	// Block buffer write: the block is kept as sixteen big-endian words,
	// one byte lane written per cycle.
	always_ff @(posedge clk) begin
		if (cmd.load_op != LOAD_NONE) begin
			block_q[cmd.load_addr[5:2]][{~cmd.load_addr[1:0], 3'b000} +: 8] <= wr_byte;
		end
	end

	// Message length in bits, wrapping modulo 2^64.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_count_q <= '0;
		end else if (cmd.finish) begin
			bit_count_q <= '0;
		end else if (cmd.count_byte) begin
			bit_count_q <= bit_count_q + 64'd8;
		end
	end

	// Schedule word for the current round.
	assign ridx = cmd.round_idx;
	always_comb begin
		word_t w2, w15;
		w2  = sched_q[4'(ridx - 6'd2)];
		w15 = sched_q[4'(ridx - 6'd15)];
		s0  = rotr(w15, 7) ^ rotr(w15, 18) ^ (w15 >> 3);
		s1  = rotr(w2, 17) ^ rotr(w2, 19) ^ (w2 >> 10);
		w_in = block_q[ridx[3:0]];
		w_new = (ridx < 6'd16) ? w_in
			: s1 + sched_q[4'(ridx - 6'd7)] + s0 + sched_q[ridx[3:0]];
		t1 = var_q[7] + (rotr(var_q[4], 6) ^ rotr(var_q[4], 11) ^ rotr(var_q[4], 25))
			+ ((var_q[4] & var_q[5]) ^ (~var_q[4] & var_q[6])) + RoundK[ridx] + w_new;
		t2 = (rotr(var_q[0], 2) ^ rotr(var_q[0], 13) ^ rotr(var_q[0], 22))
			+ ((var_q[0] & var_q[1]) ^ (var_q[0] & var_q[2]) ^ (var_q[1] & var_q[2]));
	end

	// Round variables and schedule window.
	always_ff @(posedge clk) begin
		if (cmd.comp_start) begin
			for (int j = 0; j < 8; j++) var_q[j] <= chain_q[j];
		end else if (cmd.comp_round) begin
			sched_q[ridx[3:0]] <= w_new;
			var_q[7] <= var_q[6];
			var_q[6] <= var_q[5];
			var_q[5] <= var_q[4];
			var_q[4] <= var_q[3] + t1;
			var_q[3] <= var_q[2];
			var_q[2] <= var_q[1];
			var_q[1] <= var_q[0];
			var_q[0] <= t1 + t2;
		end
	end

	// Chaining state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < 8; j++) chain_q[j] <= init_hash(3'(j));
		end else if (cmd.finish) begin
			for (int j = 0; j < 8; j++) chain_q[j] <= init_hash(3'(j));
		end else if (cmd.comp_done) begin
			for (int j = 0; j < 8; j++) chain_q[j] <= chain_q[j] + var_q[j];
		end
	end

	assign digest_word = chain_q[cmd.out_idx];

endmodule

FILE: rtl/sha256_ctrl.sv
// Controller of the SHA-256 hasher: input handshake, padding sequence, round
// counter and digest output sequence. Depends on sha256_pkg.
module sha256_ctrl
	import sha256_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       byte_present,
	input  logic       end_of_message,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [2:0] word_index,
	output logic       last_word,
	output sha_cmd_t   cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_START,
		ST_ROUND,
		ST_DONE,
		ST_PAD,
		ST_OUT
	} state_t;

	state_t     state_q;
	logic [5:0] fill_q;
	logic [5:0] pad_q;
	logic [5:0] round_q;
	logic [2:0] out_q;
	logic       ending_q;   // message end pending after this compression
	logic       final_q;    // this compression is the last block
	logic       in_fire, out_fire;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign out_valid = (state_q == ST_OUT);
	assign out_fire  = out_valid && out_ready;
	assign word_index = out_q;
	assign last_word  = (out_q == 3'd7);

	// Commands decoded from state.
	always_comb begin
		cmd = '0;
		cmd.round_idx = round_q;
		cmd.out_idx   = out_q;
		case (state_q)
			ST_IDLE: begin
				if (in_fire && byte_present) begin
					cmd.load_op    = LOAD_BYTE;
					cmd.load_addr  = fill_q;
					cmd.count_byte = 1'b1;
				end
			end
			ST_START: cmd.comp_start = 1'b1;
			ST_ROUND: cmd.comp_round = 1'b1;
			ST_DONE:  cmd.comp_done  = 1'b1;
			ST_PAD: begin
				cmd.load_addr = pad_q;
				if (pad_q == fill_q && !final_q) cmd.load_op = LOAD_PAD80;
				else if (final_q && pad_q >= 6'd56) cmd.load_op = LOAD_LEN;
				else cmd.load_op = LOAD_ZERO;
			end
			ST_OUT: cmd.finish = out_fire && last_word;
			default: ;
		endcase
	end

	// State, counters and padding flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			fill_q   <= '0;
			pad_q    <= '0;
			round_q  <= '0;
			out_q    <= '0;
			ending_q <= 1'b0;
			final_q  <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						if (byte_present) fill_q <= fill_q + 6'd1;
						ending_q <= end_of_message;
						final_q  <= 1'b0;
						if (byte_present && fill_q == 6'd63) begin
							state_q <= ST_START;
						end else if (end_of_message) begin
							pad_q   <= byte_present ? fill_q + 6'd1 : fill_q;
							state_q <= ST_PAD;
						end
					end
				end
				ST_START: begin
					round_q <= '0;
					state_q <= ST_ROUND;
				end
				ST_ROUND: begin
					round_q <= round_q + 6'd1;
					if (round_q == 6'd63) state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (final_q) begin
						out_q   <= '0;
						state_q <= ST_OUT;
					end else if (ending_q) begin
						// A full block ended with the message when fill_q is zero; then
						// the marker starts the next block. A spilled marker block leaves
						// fill_q nonzero, and the next block holds only zeros and length.
						pad_q   <= '0;
						fill_q  <= '0;
						final_q <= (fill_q != 6'd0);
						state_q <= ST_PAD;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_PAD: begin
					pad_q <= pad_q + 6'd1;
					if (pad_q == 6'd63) begin
						// Without final_q the length did not fit behind the marker.
						state_q <= ST_START;
					end else if (pad_q == fill_q && !final_q && fill_q < 6'd56) begin
						final_q <= 1'b1;
					end
				end
				ST_OUT: begin
					if (out_fire) begin
						out_q <= out_q + 3'd1;
						if (last_word) begin
							fill_q  <= '0;
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

FILE: rtl/sha256_stream_hasher_core.sv
// SHA-256 stream hasher, top level: joins controller and datapath.
// Depends on sha256_pkg, sha256_ctrl and sha256_datapath.
//
// Accepts one message byte per transfer while a block fills; the 64th byte of a
// block starts a compression (one round per cycle through the shared round
// unit), during which no byte is taken. The final item pads the rest of the
// block at one byte per cycle and compresses it; when fewer than nine bytes
// were free it also needs a second padded block and its compression. The eight
// digest words then leave one per output transfer, most significant first, and
// the hasher is ready for a new message.
module sha256_stream_hasher_core
	import sha256_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  message_byte,
	input  logic        byte_present,
	input  logic        end_of_message,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last_word
);

	sha_cmd_t cmd;

	sha256_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.byte_present(byte_present), .end_of_message(end_of_message),
		.out_valid(out_valid), .out_ready(out_ready),
		.word_index(word_index), .last_word(last_word), .cmd(cmd)
	);

	sha256_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd),
		.message_byte(message_byte), .digest_word(digest_word)
	);

	// No input is taken while digest words are pending.
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid)) else $error("input and output active together");

	// Word index advances by one after each output transfer that is not the last.
	a_idx_step: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_word |=> word_index == $past(word_index) + 3'd1)
		else $error("word index did not advance");

	// After the last word the hasher takes input again.
	a_back_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && last_word |=> in_ready)
		else $error("not idle after digest");

endmodule
